// File: src/iqd_pkg.sv
// ============================================================================
// iqd_pkg
// Shared types, mode codes and arithmetic constants for the I/Q demodulator.
// ============================================================================
package iqd_pkg;

    // Demodulation mode codes
    localparam logic [1:0] MODE_FM  = 2'd0;
    localparam logic [1:0] MODE_USB = 2'd1;
    localparam logic [1:0] MODE_LSB = 2'd2;
    localparam logic [1:0] MODE_AM  = 2'd3;

    // CORDIC sizing
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W       = $clog2(ATAN_LEN);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Shared multiplier operands (signed 25 x 25)
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [MUL_W-1:0] AM_ALPHA = 25'sd251772;
    localparam logic signed [MUL_W-1:0] AM_BETA  = 25'sd104287;
    localparam logic signed [MUL_W-1:0] LEAK_MUL = 25'sd6711;
    // ceil(2^18 / 5): exact floor(a / 5) for a below 2^18
    localparam logic signed [MUL_W-1:0] DIV5_MUL = 25'sd52429;

    localparam logic [47:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;

    // One queued sample with the mode it was taken under
    typedef struct packed {
        logic [1:0]          mode;
        logic signed [15:0]  i;
        logic signed [15:0]  q;
    } item_t;

    // atan(2^-k) / pi in Q30
    function automatic logic [29:0] atan_pi_q30(input logic [STEP_W-1:0] k);
        logic [29:0] v;
        begin
            case (k)
                5'd0:    v = 30'd268435456;
                5'd1:    v = 30'd158466703;
                5'd2:    v = 30'd83729454;
                5'd3:    v = 30'd42502378;
                5'd4:    v = 30'd21333666;
                5'd5:    v = 30'd10677233;
                5'd6:    v = 30'd5339919;
                5'd7:    v = 30'd2670123;
                5'd8:    v = 30'd1335082;
                5'd9:    v = 30'd667543;
                5'd10:   v = 30'd333772;
                5'd11:   v = 30'd166886;
                5'd12:   v = 30'd83443;
                5'd13:   v = 30'd41722;
                5'd14:   v = 30'd20861;
                5'd15:   v = 30'd10430;
                5'd16:   v = 30'd5215;
                5'd17:   v = 30'd2608;
                5'd18:   v = 30'd1304;
                5'd19:   v = 30'd652;
                5'd20:   v = 30'd326;
                5'd21:   v = 30'd163;
                5'd22:   v = 30'd81;
                5'd23:   v = 30'd41;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: src/iqd_front.sv
// ============================================================================
// iqd_front
// Input side: holds the mode register and tags each accepted sample with
// the mode in force, in a one-entry stage ahead of the queue.
// ============================================================================
module iqd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   in_phase,
    input  logic signed [15:0]   quad_phase,
    output logic                 push_valid,
    input  logic                 push_ready,
    output iqd_pkg::item_t       push_item
);

    logic            mode_reg;
    logic [1:0]      mode_val_reg;
    logic            stage_valid_reg;
    iqd_pkg::item_t  stage_item_reg;
    logic            accept;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    // Mode register, written only while the block is idle: user rule, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_val_reg <= iqd_pkg::MODE_FM;
            mode_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_val_reg <= cfg_wr_data;
            mode_reg     <= 1'b1;
        end
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (push_ready)
            stage_valid_reg <= 1'b0;
    end

    // Stage payload: sample tagged with its mode
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.mode <= mode_reg ? mode_val_reg : iqd_pkg::MODE_FM;
            stage_item_reg.i    <= in_phase;
            stage_item_reg.q    <= quad_phase;
        end
    end

endmodule

// File: src/iqd_queue.sv
// ============================================================================
// iqd_queue
// Short register queue decoupling the input stage from the execution unit.
// ============================================================================
module iqd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  iqd_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output iqd_pkg::item_t  pop_item
);

    localparam logic [iqd_pkg::QPTR_W-1:0] LAST_PTR =
        iqd_pkg::QPTR_W'(iqd_pkg::QUEUE_DEPTH - 1);
    localparam logic [iqd_pkg::QCNT_W-1:0] FULL_CNT =
        iqd_pkg::QCNT_W'(iqd_pkg::QUEUE_DEPTH);

    iqd_pkg::item_t                 entry_reg [iqd_pkg::QUEUE_DEPTH];
    logic [iqd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [iqd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [iqd_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: src/iqd_back.sv
// ============================================================================
// iqd_back
// Execution unit: sequencer around one shared multiplier. Runs the FM
// discriminator (products, normalize, iterative CORDIC, scale), the sideband
// sums and the AM envelope with DC block, then holds the result for output.
// ============================================================================
module iqd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  iqd_pkg::item_t       pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   audio_sample
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_NORM   = 4'd3;
    localparam logic [3:0] S_ROT    = 4'd4;
    localparam logic [3:0] S_CORD   = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_SIGN   = 4'd7;
    localparam logic [3:0] S_SB     = 4'd8;
    localparam logic [3:0] S_AM     = 4'd9;
    localparam logic [3:0] S_AMLEAK = 4'd10;
    localparam logic [3:0] S_AMOUT  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic signed [47:0] LIM32     = 48'sh0000_0001_0000_0000;
    localparam logic signed [47:0] LIM40     = 48'sh0000_0100_0000_0000;
    localparam logic signed [31:0] Z_HALF_PI = 32'sd536870912;
    localparam logic [iqd_pkg::STEP_W-1:0] CORD_LAST =
        iqd_pkg::STEP_W'(iqd_pkg::CORDIC_ITERS - 1);

    localparam logic [1:0] M0 = 2'd0;
    localparam logic [1:0] M1 = 2'd1;
    localparam logic [1:0] M2 = 2'd2;
    localparam logic [1:0] M3 = 2'd3;

    logic [3:0]                           state_reg, state_next;
    logic [iqd_pkg::STEP_W-1:0]           cnt_reg, cnt_next;
    iqd_pkg::item_t                       item_reg, item_next;
    logic signed [iqd_pkg::PROD_W-1:0]    p_reg, p_next;
    logic signed [47:0]                   x_reg, x_next;
    logic signed [47:0]                   y_reg, y_next;
    logic signed [31:0]                   z_reg, z_next;
    logic                                 zneg_reg, zneg_next;
    logic signed [15:0]                   prev_i_reg, prev_i_next;
    logic signed [15:0]                   prev_q_reg, prev_q_next;
    logic [47:0]                          acc_reg, acc_next;
    logic [33:0]                          mag_reg, mag_next;
    logic [36:0]                          leak_lo_reg, leak_lo_next;
    logic [34:0]                          leak_reg, leak_next;
    logic signed [15:0]                   res_reg, res_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [15:0]                   audio_reg, audio_next;

    logic signed [iqd_pkg::MUL_W-1:0]     ma, mb;
    logic signed [iqd_pkg::PROD_W-1:0]    prod;
    logic signed [16:0]                   i17, q17;
    logic [16:0]                          ai, aq, mx, mn;
    logic signed [31:0]                   zabs;
    logic signed [47:0]                   y_sum;
    logic signed [47:0]                   xs, ys;
    logic                                 in32, in40;
    logic [61:0]                          leak_sum;
    logic [48:0]                          acc_sum;
    logic signed [35:0]                   d_am;
    logic [35:0]                          d_abs;
    logic signed [18:0]                   am_v, fm_v, sb_v;
    logic [29:0]                          atan_k;
    logic                                 out_free;

    // Saturate to +-32767
    function automatic logic signed [15:0] sat_audio(input logic signed [18:0] v);
        logic signed [15:0] r;
        begin
            if (v > 19'sd32767)
                r = 16'sd32767;
            else if (v < -19'sd32767)
                r = -16'sd32767;
            else
                r = v[15:0];
            return r;
        end
    endfunction

    assign out_valid    = out_valid_reg;
    assign audio_sample = audio_reg;
    assign pop_ready    = (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || out_ready;

    // Operand prep: magnitudes, min/max, |z|
    always_comb
    begin
        i17  = 17'(item_reg.i);
        q17  = 17'(item_reg.q);
        ai   = i17[16] ? 17'(-i17) : 17'(i17);
        aq   = q17[16] ? 17'(-q17) : 17'(q17);
        mx   = (ai > aq) ? ai : aq;
        mn   = (ai > aq) ? aq : ai;
        zabs = z_reg[31] ? -z_reg : z_reg;
    end

    // Shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_MUL:
            begin
                unique case (cnt_reg[1:0])
                    M0: begin ma = 25'(item_reg.i); mb = 25'(prev_i_reg); end
                    M1: begin ma = 25'(item_reg.q); mb = 25'(prev_q_reg); end
                    M2: begin ma = 25'(item_reg.q); mb = 25'(prev_i_reg); end
                    M3: begin ma = 25'(item_reg.i); mb = 25'(prev_q_reg); end
                endcase
            end
            S_AM:
            begin
                unique case (cnt_reg[1:0])
                    M0: begin ma = signed'({8'd0, mx}); mb = iqd_pkg::AM_ALPHA; end
                    M1: begin ma = signed'({8'd0, mn}); mb = iqd_pkg::AM_BETA; end
                    M2: begin ma = signed'({1'b0, acc_reg[23:0]}); mb = iqd_pkg::LEAK_MUL; end
                    M3: begin ma = signed'({1'b0, acc_reg[47:24]}); mb = iqd_pkg::LEAK_MUL; end
                endcase
            end
            S_DIV:
            begin
                ma = signed'({9'd0, zabs[31:16]});
                mb = iqd_pkg::DIV5_MUL;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = ma * mb;
    end

    // Datapath helpers
    always_comb
    begin
        y_sum    = y_reg - {{16{p_reg[31]}}, p_reg[31:0]};
        in32     = (x_reg < LIM32) && (x_reg > -LIM32) && (y_reg < LIM32) && (y_reg > -LIM32);
        in40     = (x_reg < LIM40) && (x_reg > -LIM40) && (y_reg < LIM40) && (y_reg > -LIM40);
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        atan_k   = iqd_pkg::atan_pi_q30(cnt_reg);
        leak_sum = 62'({p_reg[36:0], 24'd0}) + 62'(leak_lo_reg);
        acc_sum  = 49'(acc_reg) - 49'(leak_reg) + 49'(mag_reg);
        d_am     = signed'(36'(mag_reg)) - signed'(36'(leak_reg));
        d_abs    = d_am[35] ? 36'(-d_am) : 36'(d_am);
        am_v     = d_am[35] ? -signed'({1'b0, d_abs[35:18]}) : signed'({1'b0, d_abs[35:18]});
        fm_v     = zneg_reg ? -signed'({3'd0, p_reg[33:18]}) : signed'({3'd0, p_reg[33:18]});
        sb_v     = (item_reg.mode == iqd_pkg::MODE_USB)
                 ? 19'(item_reg.i) + 19'(item_reg.q)
                 : 19'(item_reg.i) - 19'(item_reg.q);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        item_next      = item_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zneg_next      = zneg_reg;
        prev_i_next    = prev_i_reg;
        prev_q_next    = prev_q_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        leak_lo_next   = leak_lo_reg;
        leak_next      = leak_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        audio_next     = audio_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    item_next = pop_item;
                    cnt_next  = '0;
                    unique case (pop_item.mode)
                        iqd_pkg::MODE_FM:  state_next = S_MUL;
                        iqd_pkg::MODE_USB: state_next = S_SB;
                        iqd_pkg::MODE_LSB: state_next = S_SB;
                        iqd_pkg::MODE_AM:  state_next = S_AM;
                    endcase
                end
            end

            // FM cross products, one per cycle
            S_MUL:
            begin
                p_next   = prod;
                cnt_next = cnt_reg + 1'b1;
                unique case (cnt_reg[1:0])
                    M0: ;
                    M1: x_next = {{16{p_reg[31]}}, p_reg[31:0]};
                    M2: x_next = x_reg + {{16{p_reg[31]}}, p_reg[31:0]};
                    M3:
                    begin
                        y_next     = {{16{p_reg[31]}}, p_reg[31:0]};
                        state_next = S_SUM;
                    end
                endcase
            end

            S_SUM:
            begin
                y_next      = y_sum;
                prev_i_next = item_reg.i;
                prev_q_next = item_reg.q;
                if (x_reg == '0 && y_sum == '0)
                begin
                    z_next     = '0;
                    state_next = S_DIV;
                end
                else
                    state_next = S_NORM;
            end

            // Scale up until one magnitude reaches 2^40
            S_NORM:
            begin
                if (in32)
                begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end
                else if (in40)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                    state_next = S_ROT;
            end

            // Fold left half-plane by a quarter turn
            S_ROT:
            begin
                cnt_next   = '0;
                state_next = S_CORD;
                if (x_reg[47])
                begin
                    if (!y_reg[47])
                    begin
                        x_next = y_reg;
                        y_next = -x_reg;
                        z_next = Z_HALF_PI;
                    end
                    else
                    begin
                        x_next = -y_reg;
                        y_next = x_reg;
                        z_next = -Z_HALF_PI;
                    end
                end
                else
                    z_next = '0;
            end

            // One CORDIC vectoring step per cycle
            S_CORD:
            begin
                if (!y_reg[47] && y_reg != '0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + signed'({2'b00, atan_k});
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - signed'({2'b00, atan_k});
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                    state_next = S_DIV;
            end

            // |z| / 327680 = (|z| >> 16) / 5 via reciprocal
            S_DIV:
            begin
                p_next     = prod;
                zneg_next  = z_reg[31];
                state_next = S_SIGN;
            end

            S_SIGN:
            begin
                res_next   = sat_audio(fm_v);
                state_next = S_OUT;
            end

            S_SB:
            begin
                res_next   = sat_audio(sb_v);
                state_next = S_OUT;
            end

            // AM magnitude and leak products
            S_AM:
            begin
                p_next   = prod;
                cnt_next = cnt_reg + 1'b1;
                unique case (cnt_reg[1:0])
                    M0: ;
                    M1: mag_next = p_reg[33:0];
                    M2:
                    begin
                        mag_next = mag_reg + p_reg[33:0];
                    end
                    M3:
                    begin
                        leak_lo_next = p_reg[36:0];
                        state_next   = S_AMLEAK;
                    end
                endcase
            end

            S_AMLEAK:
            begin
                leak_next  = leak_sum[60:26];
                state_next = S_AMOUT;
            end

            // DC block update and output
            S_AMOUT:
            begin
                acc_next   = acc_sum[48] ? iqd_pkg::ACC_MAX : acc_sum[47:0];
                res_next   = sat_audio(am_v);
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    audio_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
            acc_reg       <= acc_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        p_reg       <= p_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zneg_reg    <= zneg_next;
        mag_reg     <= mag_next;
        leak_lo_reg <= leak_lo_next;
        leak_reg    <= leak_next;
        res_reg     <= res_next;
        audio_reg   <= audio_next;
    end

endmodule

// File: src/iq_am_fm_ssb_demodulator_unit.sv
// ============================================================================
// iq_am_fm_ssb_demodulator_unit
// I/Q demodulator: FM discriminator, USB/LSB sum, AM envelope with DC block.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one Q15 I/Q sample per beat;
//   output channel (out_valid/out_ready) returns one Q15 audio sample per
//   input beat, in order. cfg_wr_en/cfg_wr_data write the 2-bit mode
//   (FM, USB, LSB, AM); write it only while no sample is in flight.
//   Samples enter an input stage, then a two-entry queue, then a sequencer
//   built around one shared 25x25 multiplier that handles one sample at a time.
//   Sequencer steps per sample: USB/LSB a sum or difference, AM its products,
//   leak and DC-block update, FM 4 products, normalize shifts, 16 CORDIC
//   steps, reciprocal scale and sign; FM with a zero product skips normalize
//   and CORDIC; the CORDIC loop sets the FM rate. Input stage and queue sit
//   ahead of the sequencer; the queue overlaps the sequencer's idle state.
//   Reset clears the mode to FM, the FM history and the AM accumulator.
//   A stalled receiver holds the result register; the queue keeps filling and
//   in_ready drops once input stage and queue are full.
// ============================================================================
module iq_am_fm_ssb_demodulator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   in_phase,
    input  logic signed [15:0]   quad_phase,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   audio_sample
);

    logic            push_valid;
    logic            push_ready;
    iqd_pkg::item_t  push_item;
    logic            pop_valid;
    logic            pop_ready;
    iqd_pkg::item_t  pop_item;

    // Input stage and mode register
    iqd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_phase    (in_phase),
        .quad_phase  (quad_phase),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // Decoupling queue
    iqd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Execution unit and output register
    iqd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .audio_sample (audio_sample)
    );

endmodule
